### sv/wasm_subset_stack_machine_core_macros.svh
// Assertion helpers used by the RTL back end (wsm_back).
`ifndef WASM_SUBSET_STACK_MACHINE_CORE_MACROS_SVH
`define WASM_SUBSET_STACK_MACHINE_CORE_MACROS_SVH

// Assert that prop holds at every rising edge outside reset.
`define WSM_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Assert that cons holds in the cycle after ante.
`define WSM_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

### sv/wsm_pkg.sv
package wsm_pkg;

  localparam int unsigned StackDepthDef = 64;
  localparam int unsigned PageBytesDef  = 4096;
  localparam int unsigned PageCapDef    = 32;
  localparam int unsigned TableLen      = 2;

  localparam logic [7:0] OpUnreach = 8'h00;
  localparam logic [7:0] OpRet     = 8'h0f;
  localparam logic [7:0] OpCall    = 8'h11;
  localparam logic [7:0] OpLoad    = 8'h28;
  localparam logic [7:0] OpStore   = 8'h36;
  localparam logic [7:0] OpGrow    = 8'h40;
  localparam logic [7:0] OpConst   = 8'h41;
  localparam logic [7:0] OpAdd     = 8'h6a;
  localparam logic [7:0] OpDrop    = 8'h1a;

  localparam logic [2:0] TrapNone    = 3'd0;
  localparam logic [2:0] TrapUnreach = 3'd1;
  localparam logic [2:0] TrapMem     = 3'd2;
  localparam logic [2:0] TrapTable   = 3'd3;
  localparam logic [2:0] TrapUnder   = 3'd4;
  localparam logic [2:0] TrapOver    = 3'd5;
  localparam logic [2:0] TrapDecode  = 3'd6;

  // Command classes passed from front end to back end.
  typedef enum logic [3:0] {
    CmdNop, CmdUnreach, CmdRet, CmdCall, CmdLoad, CmdStore, CmdGrow,
    CmdConst, CmdAdd, CmdDrop, CmdDecode, CmdEnd
  } cmd_e;

  typedef struct packed {
    cmd_e        cmd;
    logic        last;
    logic [31:0] imm;
  } cmd_t;

  typedef enum logic [3:0] {
    StClear, StIdle, StPop1, StPop2, StMem, StMul, StPush, StOut, StSkip
  } exec_state_e;

endpackage

### sv/wsm_front.sv
module wsm_front (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  output logic          full_o,
  input  logic [7:0]    code_byte_i,
  input  logic          last_byte_i,
  output logic          cmd_valid_o,
  output wsm_pkg::cmd_t cmd_o,
  input  logic          cmd_full_i
);
  import wsm_pkg::*;

  logic [2:0]  imm_left_q, imm_left_d;
  logic [31:0] imm_acc_q, imm_acc_d;
  logic        is_const_q, is_const_d;
  logic        acc;

  assign full_o = cmd_full_i;
  assign acc    = push_i && !cmd_full_i;
  assign cmd_valid_o = acc;

  always_comb begin
    imm_left_d = imm_left_q;
    imm_acc_d  = imm_acc_q;
    is_const_d = is_const_q;
    cmd_o.cmd  = CmdNop;
    cmd_o.last = last_byte_i;
    cmd_o.imm  = '0;
    if (imm_left_q != 3'd0) begin
      imm_acc_d  = {code_byte_i, imm_acc_q[31:8]};
      imm_left_d = imm_left_q - 3'd1;
      cmd_o.imm  = imm_acc_d;
      if (imm_left_d == 3'd0) begin
        cmd_o.cmd = is_const_q ? CmdConst : CmdCall;
      end else if (last_byte_i) begin
        cmd_o.cmd = CmdDecode;
      end
    end else begin
      unique case (code_byte_i)
        OpConst, OpCall: begin
          is_const_d = (code_byte_i == OpConst);
          imm_acc_d  = '0;
          imm_left_d = (code_byte_i == OpConst) ? 3'd4 : 3'd2;
          cmd_o.cmd  = last_byte_i ? CmdDecode : CmdNop;
        end
        OpUnreach: cmd_o.cmd = CmdUnreach;
        OpRet:     cmd_o.cmd = CmdRet;
        OpLoad:    cmd_o.cmd = CmdLoad;
        OpStore:   cmd_o.cmd = CmdStore;
        OpGrow:    cmd_o.cmd = CmdGrow;
        OpAdd:     cmd_o.cmd = CmdAdd;
        OpDrop:    cmd_o.cmd = CmdDrop;
        default:   cmd_o.cmd = CmdDecode;
      endcase
    end
    if (last_byte_i) imm_left_d = 3'd0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      imm_left_q <= '0;
      imm_acc_q  <= '0;
      is_const_q <= 1'b0;
    end else if (acc) begin
      imm_left_q <= imm_left_d;
      imm_acc_q  <= imm_acc_d;
      is_const_q <= is_const_d;
    end
  end
endmodule

### sv/wsm_cmd_fifo.sv
module wsm_cmd_fifo (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          wr_i,
  input  wsm_pkg::cmd_t wdata_i,
  output logic          full_o,
  input  logic          rd_i,
  output wsm_pkg::cmd_t rdata_o,
  output logic          empty_o
);
  import wsm_pkg::*;

  cmd_t       mem_q [4];
  logic [1:0] wp_q, rp_q;
  logic [2:0] cnt_q;

  assign full_o  = cnt_q == 3'd4;
  assign empty_o = cnt_q == 3'd0;
  assign rdata_o = mem_q[rp_q];

  always_ff @(posedge clk_i) begin
    if (wr_i && !full_o) mem_q[wp_q] <= wdata_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q <= '0;
      rp_q <= '0;
      cnt_q <= '0;
    end else begin
      if (wr_i && !full_o) wp_q <= wp_q + 2'd1;
      if (rd_i && !empty_o) rp_q <= rp_q + 2'd1;
      cnt_q <= cnt_q + {2'b0, wr_i && !full_o} - {2'b0, rd_i && !empty_o};
    end
  end
endmodule

### sv/wsm_back.sv
module wsm_back #(
  parameter int unsigned StackDepth = wsm_pkg::StackDepthDef,
  parameter int unsigned PageBytes  = wsm_pkg::PageBytesDef,
  parameter int unsigned PageCap    = wsm_pkg::PageCapDef
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          cmd_empty_i,
  input  wsm_pkg::cmd_t cmd_i,
  output logic          cmd_pop_o,
  output logic          empty_o,
  input  logic          pop_i,
  output logic [31:0]   result_value_o,
  output logic [2:0]    trap_code_o
);
  import wsm_pkg::*;
`include "wasm_subset_stack_machine_core_macros.svh"

  localparam int unsigned SpW   = $clog2(StackDepth + 1);
  localparam int unsigned SaW   = $clog2(StackDepth);
  localparam int unsigned MemN  = PageCap * PageBytes;
  localparam int unsigned MaW   = $clog2(MemN);
  localparam int unsigned PgW   = $clog2(PageCap + 1);
  localparam logic [31:0] PageB = 32'(PageBytes);
  localparam logic [31:0] CapP  = 32'(PageCap);

  exec_state_e st_q, st_d;
  logic [31:0] stk_q [StackDepth];
  logic [7:0]  mem_q [MemN];
  logic [SpW-1:0] sp_q, sp_d;
  logic [PgW-1:0] pages_q, pages_d;
  logic [MaW-1:0] clr_q;
  logic        done_q, done_d;
  cmd_t        cur_q, cur_d;
  logic [31:0] a_q, a_d, b_q, b_d;
  logic [1:0]  bi_q, bi_d;
  logic [31:0] rv_q, rv_d;
  logic [2:0]  tc_q, tc_d;
  logic        ov_q, ov_d;
  logic [31:0] res_val_q;
  logic [2:0]  res_trap_q;
  logic        out_load;
  logic [7:0]  rd_q;
  logic [31:0] top_q;
  logic        stk_we, mem_we;
  logic [SaW-1:0] stk_wa, stk_ra_d;
  logic [31:0] stk_wd, mem_addr;
  logic [7:0]  mem_wd;
  logic [31:0] size_b;
  logic        addr_ok;

  // top_q always holds the entry just below the stack pointer
  assign stk_ra_d = SaW'(sp_d - SpW'(1));
  assign size_b  = 32'(pages_q) * PageB;
  assign addr_ok = !a_q[31] && size_b >= 32'd4 && a_q <= size_b - 32'd4;
  assign empty_o = !ov_q;
  assign result_value_o = res_val_q;
  assign trap_code_o = res_trap_q;
  assign mem_addr = a_q + 32'(bi_q);

  always_comb begin
    st_d = st_q; sp_d = sp_q; pages_d = pages_q; done_d = done_q; cur_d = cur_q;
    a_d = a_q; b_d = b_q; bi_d = bi_q; out_load = 1'b0;
    rv_d = rv_q; tc_d = tc_q; cmd_pop_o = 1'b0;
    stk_we = 1'b0; stk_wa = SaW'(sp_q); stk_wd = '0;
    mem_we = 1'b0; mem_wd = '0;
    unique case (st_q)
      StClear: if (clr_q == MaW'(MemN - 1)) st_d = StIdle;
      StIdle: if (!cmd_empty_i) begin
        cmd_pop_o = 1'b1;
        cur_d = cmd_i;
        if (done_q) begin
          if (cmd_i.last) begin
            done_d = 1'b0; sp_d = '0;
          end
        end else begin
          unique case (cmd_i.cmd)
            CmdNop: if (cmd_i.last) st_d = StPop1;
            CmdUnreach: begin tc_d = TrapUnreach; st_d = StOut; end
            CmdDecode: begin tc_d = TrapDecode; st_d = StOut; end
            CmdConst: begin
              b_d = cmd_i.imm;
              st_d = StPush;
            end
            default: st_d = StPop1;
          endcase
        end
      end
      StPop1: begin
        if (sp_q == '0) begin
          tc_d = TrapUnder; st_d = StOut;
        end else begin
          sp_d = sp_q - SpW'(1);
          unique case (cur_q.cmd)
            CmdNop, CmdRet: begin rv_d = top_q; tc_d = TrapNone; st_d = StOut; end
            CmdDrop: st_d = StPush;
            CmdLoad: begin a_d = top_q; bi_d = '0; st_d = StMem; end
            CmdGrow: begin
              a_d = top_q;
              if (top_q[31]) begin tc_d = TrapDecode; st_d = StOut; end
              else begin
                if (32'(pages_q) > CapP || top_q > CapP - 32'(pages_q)) b_d = '1;
                else begin
                  b_d = 32'(pages_q);
                  pages_d = PgW'(32'(pages_q) + top_q);
                end
                st_d = StPush;
              end
            end
            CmdCall: begin
              if (top_q >= 32'(TableLen)) begin tc_d = TrapTable; st_d = StOut; end
              else begin b_d = top_q; st_d = StPop2; end
            end
            default: begin b_d = top_q; st_d = StPop2; end
          endcase
        end
      end
      StPop2: begin
        if (sp_q == '0) begin
          tc_d = TrapUnder; st_d = StOut;
        end else begin
          sp_d = sp_q - SpW'(1);
          a_d = top_q;
          unique case (cur_q.cmd)
            CmdAdd: begin b_d = top_q + b_q; st_d = StPush; end
            CmdStore: begin bi_d = '0; st_d = StMem; end
            default: begin
              if (b_q[0]) st_d = StMul;
              else begin b_d = top_q + 32'd1; st_d = StPush; end
            end
          endcase
        end
      end
      StMul: begin b_d = a_q * a_q; st_d = StPush; end
      StMem: begin
        if (!addr_ok) begin tc_d = TrapMem; st_d = StOut; end
        else if (cur_q.cmd == CmdStore) begin
          mem_we = 1'b1;
          mem_wd = b_q[8*bi_q +: 8];
          bi_d = bi_q + 2'd1;
          if (bi_q == 2'd3) st_d = cur_q.last ? StPop1 : StIdle;
          if (bi_q == 2'd3) cur_d.cmd = CmdNop;
        end else begin
          // read data comes through the registered rd_q; shift it in from StSkip
          st_d = StSkip;
        end
      end
      StSkip: begin
        b_d = {rd_q, b_q[31:8]};
        bi_d = bi_q + 2'd1;
        st_d = (bi_q == 2'd3) ? StPush : StMem;
      end
      StPush: begin
        if (cur_q.cmd != CmdDrop) begin
          if (sp_q >= SpW'(StackDepth)) begin
            tc_d = TrapOver; st_d = StOut;
          end else begin
            stk_we = 1'b1; stk_wd = b_q; sp_d = sp_q + SpW'(1);
          end
        end
        if (st_d == StPush) begin
          st_d = cur_q.last ? StPop1 : StIdle;
          cur_d.cmd = CmdNop;
        end
      end
      StOut: begin
        // hold until the result register is free or being emptied
        if (!ov_q || pop_i) begin
          out_load = 1'b1;
          if (cur_q.last) begin
            sp_d = '0; done_d = 1'b0;
          end else done_d = 1'b1;
          st_d = StIdle;
        end
      end
      default: st_d = StIdle;
    endcase
  end

  assign ov_d = out_load ? 1'b1 : (ov_q && !pop_i);

  always_ff @(posedge clk_i) begin
    if (stk_we) stk_q[stk_wa] <= stk_wd;
    top_q <= (stk_we && stk_wa == stk_ra_d) ? stk_wd : stk_q[stk_ra_d];
  end

  always_ff @(posedge clk_i) begin
    if (st_q == StClear) mem_q[clr_q] <= '0;
    else if (mem_we) mem_q[mem_addr[MaW-1:0]] <= mem_wd;
    rd_q <= mem_q[mem_addr[MaW-1:0]];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StClear; sp_q <= '0; pages_q <= PgW'(1); done_q <= 1'b0;
      clr_q <= '0; cur_q <= '0; ov_q <= 1'b0;
      tc_q <= TrapNone; rv_q <= '0; a_q <= '0; b_q <= '0; bi_q <= '0;
      res_val_q <= '0; res_trap_q <= TrapNone;
    end else begin
      st_q <= st_d; sp_q <= sp_d; pages_q <= pages_d; done_q <= done_d;
      cur_q <= cur_d; ov_q <= ov_d;
      tc_q <= tc_d; rv_q <= rv_d; a_q <= a_d; b_q <= b_d; bi_q <= bi_d;
      if (out_load) begin
        res_val_q  <= (tc_q != TrapNone) ? '0 : rv_q;
        res_trap_q <= tc_q;
      end
      if (st_q == StClear) clr_q <= clr_q + MaW'(1);
    end
  end

  `WSM_ASSERT(a_sp_range, clk_i, rst_ni, sp_q <= SpW'(StackDepth), "stack pointer out of range")
  `WSM_ASSERT(a_pages_cap, clk_i, rst_ni, 32'(pages_q) <= CapP, "pages above limit")
  `WSM_ASSERT_NEXT(a_out_set, clk_i, rst_ni, out_load, ov_q, "result lost")
  `WSM_ASSERT(a_no_cmd_busy, clk_i, rst_ni, !(cmd_pop_o && st_q != StIdle),
              "command taken while busy")
endmodule

### sv/wasm_subset_stack_machine_core.sv
// WebAssembly-subset stack machine.
// Input channel: push/full carry one program byte (code_byte_i) with
// last_byte_i set on the final byte; an item is taken when push && !full.
// Result channel: queue style; the result (result_value_o, trap_code_o) is
// shown while empty is low and taken on a cycle with pop high.
// A front end decodes bytes and immediates in the cycle they arrive and
// writes one command into a four-entry queue; the back end runs it.
// Throughput: a byte is taken every cycle while the queue has room; the
// back end runs stack operations through its pop and push states (square
// adds a multiply step), and store and load step through the byte-wide
// memory port one byte at a time, load also through its registered read.
// A command that traps at decode goes from idle straight to the output
// state; a load as final byte is followed by a pop of its result.
// Reset: stack and decode state clear, pages in use return to one, and a
// clearing pass writes zero to every memory byte (page limit times page
// size bytes, 131072 by default) before the first command runs; bytes
// may queue meanwhile.
// A result left waiting holds the back end only once the next result is
// ready; the queue then fills and full rises.
module wasm_subset_stack_machine_core #(
  parameter int unsigned StackDepth = wsm_pkg::StackDepthDef,
  parameter int unsigned PageBytes  = wsm_pkg::PageBytesDef,
  parameter int unsigned PageCap    = wsm_pkg::PageCapDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  code_byte_i,
  input  logic        last_byte_i,
  output logic        empty,
  input  logic        pop,
  output logic signed [31:0] result_value_o,
  output logic [2:0]  trap_code_o
);
  import wsm_pkg::*;

  cmd_t fc, bc;
  logic fv, qfull, qempty, qpop;
  logic [31:0] rv;

  wsm_front u_front (
    .clk_i, .rst_ni, .push_i(push), .full_o(full), .code_byte_i, .last_byte_i,
    .cmd_valid_o(fv), .cmd_o(fc), .cmd_full_i(qfull)
  );

  // hold decoded commands between the two halves
  wsm_cmd_fifo u_fifo (
    .clk_i, .rst_ni, .wr_i(fv), .wdata_i(fc), .full_o(qfull),
    .rd_i(qpop), .rdata_o(bc), .empty_o(qempty)
  );

  wsm_back #(.StackDepth(StackDepth), .PageBytes(PageBytes), .PageCap(PageCap)) u_back (
    .clk_i, .rst_ni, .cmd_empty_i(qempty), .cmd_i(bc), .cmd_pop_o(qpop),
    .empty_o(empty), .pop_i(pop), .result_value_o(rv), .trap_code_o
  );

  assign result_value_o = signed'(rv);
endmodule

### test/wasm_subset_stack_machine_core_tb.sv
`timescale 1ns / 1ps

module wasm_subset_stack_machine_core_tb;
  import wsm_pkg::*;

  localparam int unsigned PageSize = PageBytesDef;
  localparam int unsigned MemBytes = PageCapDef * PageBytesDef;
  // Long enough to cover the memory clearing pass after reset.
  localparam int unsigned IdleLimit = 4 * MemBytes;

  typedef struct {
    logic [31:0] value;
    logic [2:0]  trap;
  } outcome_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic [7:0]  code_byte_i = '0;
  logic        last_byte_i = 1'b0;
  logic        empty;
  logic        pop = 1'b0;
  logic signed [31:0] result_value_o;
  logic [2:0]  trap_code_o;

  wasm_subset_stack_machine_core uut (
    .clk_i, .rst_ni, .push, .full, .code_byte_i, .last_byte_i,
    .empty, .pop, .result_value_o, .trap_code_o
  );

  always #5 clk_i = ~clk_i;

  // Shadow machine state
  logic [31:0] shadow_stack [StackDepthDef];
  int unsigned shadow_depth;
  logic [7:0]  shadow_mem [MemBytes];
  int unsigned shadow_pages;
  logic [7:0]  shadow_opcode;
  int unsigned shadow_imm_left;
  logic [31:0] shadow_accum;
  bit          shadow_done;

  outcome_t expected_results[$];
  logic [7:0] prog_bytes[$];
  int errors = 0;
  int results_seen = 0;
  int bytes_sent = 0;
  int programs_sent = 0;
  int idle_cycles = 0;
  bit calm = 1'b0;  // no idling on either side while set

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    errors++;
  endtask

  function automatic void reset_program();
    shadow_depth = 0;
    shadow_imm_left = 0;
    shadow_accum = '0;
    shadow_opcode = '0;
    shadow_done = 1'b0;
  endfunction

  function automatic bit pop_value(output logic [31:0] v, inout logic [2:0] trap);
    v = '0;
    if (shadow_depth == 0) begin
      trap = TrapUnder;
      return 1'b0;
    end
    shadow_depth--;
    v = shadow_stack[shadow_depth];
    return 1'b1;
  endfunction

  function automatic void push_value(input logic [31:0] v, inout logic [2:0] trap);
    if (shadow_depth >= StackDepthDef) trap = TrapOver;
    else begin
      shadow_stack[shadow_depth] = v;
      shadow_depth++;
    end
  endfunction

  function automatic bit access_fits(input logic [31:0] addr);
    longint unsigned span;
    span = longint'(shadow_pages) * PageSize;
    if (addr[31]) return 1'b0;
    return longint'(addr) + 4 <= span;
  endfunction

  function automatic void run_opcode(input logic [7:0] op, inout logic [2:0] trap,
                                     inout bit ret, inout logic [31:0] val);
    logic [31:0] a, b;
    case (op)
      OpUnreach: trap = TrapUnreach;
      OpRet: if (pop_value(a, trap)) begin
        val = a;
        ret = 1'b1;
      end
      OpLoad: begin
        if (pop_value(a, trap)) begin
          if (!access_fits(a)) trap = TrapMem;
          else push_value({shadow_mem[a + 3], shadow_mem[a + 2],
                           shadow_mem[a + 1], shadow_mem[a]}, trap);
        end
      end
      OpStore: begin
        if (pop_value(b, trap) && pop_value(a, trap)) begin
          if (!access_fits(a)) trap = TrapMem;
          else for (int i = 0; i < 4; i++) shadow_mem[a + i] = b[8*i +: 8];
        end
      end
      OpGrow: begin
        if (pop_value(a, trap)) begin
          if (a[31]) trap = TrapDecode;
          else if (a > PageCapDef - shadow_pages) push_value('1, trap);
          else begin
            b = shadow_pages;
            shadow_pages += a;
            push_value(b, trap);
          end
        end
      end
      OpAdd: if (pop_value(b, trap) && pop_value(a, trap)) push_value(a + b, trap);
      OpDrop: void'(pop_value(a, trap));
      default: trap = TrapDecode;
    endcase
  endfunction

  function automatic void finish_call(inout logic [2:0] trap);
    logic [31:0] idx, arg;
    if (!pop_value(idx, trap)) return;
    if (idx >= TableLen) begin
      trap = TrapTable;
      return;
    end
    if (!pop_value(arg, trap)) return;
    push_value(idx == 0 ? arg + 1 : arg * arg, trap);
  endfunction

  // Advance the shadow machine by one accepted byte; queue any result it ends with.
  function automatic void interpret_byte(input logic [7:0] b, input bit last);
    logic [2:0]  trap;
    logic [31:0] val;
    bit          ret;
    outcome_t    o;
    trap = TrapNone;
    val = '0;
    ret = 1'b0;
    if (shadow_done) begin
      if (last) reset_program();
      return;
    end
    if (shadow_imm_left != 0) begin
      shadow_accum = {b, shadow_accum[31:8]};
      shadow_imm_left--;
      if (shadow_imm_left == 0) begin
        if (shadow_opcode == OpConst) push_value(shadow_accum, trap);
        else finish_call(trap);
      end
    end else if (b == OpConst || b == OpCall) begin
      shadow_opcode = b;
      shadow_accum = '0;
      shadow_imm_left = (b == OpConst) ? 4 : 2;
    end else begin
      run_opcode(b, trap, ret, val);
    end
    if (trap == TrapNone && !ret) begin
      if (!last) return;
      if (shadow_imm_left != 0) trap = TrapDecode;
      else void'(pop_value(val, trap));
    end
    if (trap != TrapNone) val = '0;
    o.value = val;
    o.trap = trap;
    expected_results.push_back(o);
    if (last) reset_program();
    else shadow_done = 1'b1;
  endfunction

  // Send one item, idling first for a random number of cycles unless calm is set.
  task automatic send_byte(input logic [7:0] b, input bit last);
    int gap;
    gap = calm ? 0 : $urandom_range(0, 3);
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push <= 1'b1;
    code_byte_i <= b;
    last_byte_i <= last;
    do @(posedge clk_i); while (full);
    interpret_byte(b, last);
    bytes_sent++;
  endtask

  // Send the assembled program, flagging its final byte, and clear the buffer.
  task automatic send_program();
    foreach (prog_bytes[i]) send_byte(prog_bytes[i], i == prog_bytes.size() - 1);
    prog_bytes.delete();
    programs_sent++;
  endtask

  function automatic void emit_const(input logic [31:0] v);
    prog_bytes.push_back(OpConst);
    for (int i = 0; i < 4; i++) prog_bytes.push_back(v[8*i +: 8]);
  endfunction

  function automatic void emit_call(input logic [31:0] arg, input logic [31:0] idx);
    emit_const(arg);
    emit_const(idx);
    prog_bytes.push_back(OpCall);
    prog_bytes.push_back(8'($urandom));
    prog_bytes.push_back(8'($urandom));
  endfunction

  function automatic logic [31:0] pick_address();
    int unsigned span;
    span = shadow_pages * PageSize;
    case ($urandom_range(0, 4))
      0: return $urandom_range(0, 63);
      1: return span - 8 + $urandom_range(0, 12);
      2: return $urandom_range(0, span - 4);
      3: return $urandom;
      default: return $urandom_range(0, 2 * PageSize);
    endcase
  endfunction

  function automatic logic [31:0] pick_value();
    case ($urandom_range(0, 5))
      0: return 32'h7fff_ffff;
      1: return 32'h8000_0000;
      2: return '1;
      3: return $urandom_range(0, 9);
      default: return $urandom;
    endcase
  endfunction

  // Drive pop with a random stall before each result, none while calm.
  int pop_wait = 0;
  always @(posedge clk_i) begin
    if (pop && !empty) begin
      pop_wait = calm ? 0 : $urandom_range(0, 3);
      pop <= (pop_wait == 0);
    end else if (pop_wait > 0) begin
      pop_wait--;
      pop <= (pop_wait == 0);
    end else begin
      pop <= 1'b1;
    end
  end

  // Check each result against the oldest expectation.
  always @(posedge clk_i) begin
    outcome_t o;
    if (rst_ni && pop && !empty) begin
      results_seen++;
      if (expected_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result value %0d trap %0d",
                                  result_value_o, trap_code_o));
      end else begin
        o = expected_results.pop_front();
        if (result_value_o !== o.value)
          report_mismatch($sformatf("value %0d, want %0d", result_value_o,
                                    $signed(o.value)));
        if (trap_code_o !== o.trap)
          report_mismatch($sformatf("trap %0d, want %0d", trap_code_o, o.trap));
      end
    end
  end

  // Watchdog: end the run after a long stretch with no item moving.
  always @(posedge clk_i) begin
    if ((push && !full) || (pop && !empty)) idle_cycles = 0;
    else idle_cycles++;
    if (idle_cycles >= IdleLimit) begin
      $display("watchdog expired with %0d results outstanding", expected_results.size());
      $display("wasm_subset_stack_machine_core_tb: done, errors");
      $finish;
    end
  end

  task automatic test_values();
    emit_const(7); prog_bytes.push_back(OpRet); send_program();
    emit_const(32'h7fff_ffff); emit_const(1); prog_bytes.push_back(OpAdd); send_program();
    emit_const(32'h8000_0000); emit_const('1); prog_bytes.push_back(OpAdd);
    prog_bytes.push_back(OpRet); prog_bytes.push_back(OpUnreach); send_program();
    emit_const(3); emit_const(4); prog_bytes.push_back(OpDrop); send_program();
  endtask

  task automatic test_traps();
    prog_bytes.push_back(OpUnreach); send_program();
    prog_bytes.push_back(OpDrop); send_program();
    prog_bytes.push_back(OpRet); send_program();
    prog_bytes.push_back(8'hff); send_program();
    prog_bytes.push_back(OpConst); prog_bytes.push_back(8'h12); send_program();
    emit_const('1); prog_bytes.push_back(OpGrow); send_program();
    emit_const(32'h8000_0000); prog_bytes.push_back(OpLoad); send_program();
    emit_const(1); emit_const(2); prog_bytes.push_back(OpAdd); emit_const(9); send_program();
  endtask

  task automatic test_memory();
    emit_const(0); emit_const(32'hdead_beef); prog_bytes.push_back(OpStore);
    emit_const(1); prog_bytes.push_back(OpLoad); send_program();
    emit_const(PageSize - 4); emit_const(32'h0102_0304); prog_bytes.push_back(OpStore);
    emit_const(PageSize - 4); prog_bytes.push_back(OpLoad); send_program();
    emit_const(PageSize - 3); prog_bytes.push_back(OpLoad); send_program();
    emit_const(0); prog_bytes.push_back(OpGrow); send_program();
    emit_const(PageCapDef); prog_bytes.push_back(OpGrow); send_program();
    emit_const(1); prog_bytes.push_back(OpGrow); emit_const(PageSize);
    prog_bytes.push_back(OpLoad); prog_bytes.push_back(OpAdd); send_program();
  endtask

  task automatic test_calls();
    emit_call(32'hffff_ffff, 0); send_program();
    emit_call(32'h0001_0001, 1); send_program();
    emit_call(5, 2); send_program();
    emit_call(5, '1); send_program();
    emit_const(0); prog_bytes.push_back(OpCall); prog_bytes.push_back(8'h00);
    prog_bytes.push_back(8'h00); send_program();
  endtask

  task automatic test_stack_limit();
    for (int i = 0; i < StackDepthDef; i++) emit_const(i);
    prog_bytes.push_back(OpAdd); prog_bytes.push_back(OpRet); send_program();
    for (int i = 0; i <= StackDepthDef; i++) emit_const(i);
    send_program();
  endtask

  // Mostly well-formed programs with random content; some noise and cut-off tails.
  task automatic test_random_programs(input int target_bytes);
    int ops;
    while (bytes_sent < target_bytes) begin
      calm = (programs_sent % 40) >= 32;
      if ($urandom_range(0, 9) == 0) begin
        repeat ($urandom_range(1, 10)) prog_bytes.push_back(8'($urandom));
      end else begin
        ops = $urandom_range(1, 8);
        repeat (ops) begin
          case ($urandom_range(0, 11))
            0, 1: emit_const(pick_value());
            2: begin emit_const(pick_value()); emit_const(pick_value());
                 prog_bytes.push_back(OpAdd); end
            3: prog_bytes.push_back(OpDrop);
            4, 5: begin emit_const(pick_address()); prog_bytes.push_back(OpLoad); end
            6, 7: begin emit_const(pick_address()); emit_const(pick_value());
                 prog_bytes.push_back(OpStore); end
            8: begin emit_const($urandom_range(0, 2) == 0 ? pick_value()
                                : $urandom_range(0, 3));
                 prog_bytes.push_back(OpGrow); end
            9: emit_call(pick_value(), $urandom_range(0, 5) == 0 ? pick_value()
                                       : $urandom_range(0, 1));
            10: prog_bytes.push_back($urandom_range(0, 30) == 0 ? OpUnreach : OpAdd);
            default: prog_bytes.push_back(8'($urandom));
          endcase
        end
        case ($urandom_range(0, 5))
          0: prog_bytes.push_back(OpRet);
          1: void'(prog_bytes.pop_back());
          default: ;
        endcase
        if (prog_bytes.size() == 0) prog_bytes.push_back(OpRet);
      end
      send_program();
    end
    calm = 1'b0;
  endtask

  initial begin
    for (int i = 0; i < MemBytes; i++) shadow_mem[i] = '0;
    shadow_pages = 1;
    reset_program();
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_values();
    test_traps();
    test_memory();
    test_calls();
    test_stack_limit();
    test_random_programs(1400);
    push <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
    repeat (30) @(posedge clk_i);
    $display("covered %0d programs, %0d code bytes, %0d results checked",
             programs_sent, bytes_sent, results_seen);
    $display("pages in use at end: %0d of %0d", shadow_pages, PageCapDef);
    if (errors == 0 && expected_results.size() == 0) begin
      $display("wasm_subset_stack_machine_core_tb: done, clean");
    end else begin
      $display("wasm_subset_stack_machine_core_tb: done, errors");
    end
    $finish;
  end

endmodule
